>>> hdl/plfr_pkg.sv
// ----------------------------------------------------------------------------
// plfr_pkg: shared types and constants of the pinned LRU frame replacer.
// Holds the field widths, the sequencer state type and the control group
// that the sequencer sends to the victim search unit.
// ----------------------------------------------------------------------------
package plfr_pkg;

    // Field widths of the request and result items.
    localparam int FRAME_W = 4;
    localparam int BLOCK_W = 16;
    localparam int FILE_W  = 4;

    // Per-frame bookkeeping widths.
    localparam int STAMP_W = 32;
    localparam int PIN_W   = 8;

    // Pin counts saturate at this value.
    localparam logic [PIN_W-1:0] PIN_MAX = 8'hFF;

    // Result status codes.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_FRAME = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_LOAD,
        ST_UPDATE,
        ST_OUT
    } plfr_state_t;

    // Control from the sequencer to the victim search unit.
    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctrl_t;

endpackage

>>> hdl/pinned_lru_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// pinned_lru_frame_replacer_core: buffer-pool frame replacer.
// Picks a frame for a disk block, reports a write-back of a dirty victim and
// installs the new block with a fresh use stamp and one more pin.
// ----------------------------------------------------------------------------
// One request item is handled at a time and gives one result item. A victim
// search reads the frame records from a memory with one read port, one frame
// per cycle, into a shared stamp comparator, then passes the decide, load and
// update states before the result is offered, or goes from decide straight
// to the result when every frame is pinned. A forced frame skips the scan and
// passes load and update; a forced frame beyond the pool goes straight to the
// result. The result waits in an output register until it is taken, and
// in_stall stays high from acceptance until then. Frame records come out of
// reset as all zero through a per-frame valid bit, so no clearing pass runs.
// ----------------------------------------------------------------------------
module pinned_lru_frame_replacer_core #(
    parameter int FRAMES = 16,
    parameter int FILES  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request channel.
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           forced_valid,
    input  logic [plfr_pkg::FRAME_W-1:0]   forced_frame,
    input  logic [plfr_pkg::BLOCK_W-1:0]   block_number,
    input  logic [plfr_pkg::FILE_W-1:0]    file_id,
    input  logic                           dirty_on_load,
    // Result channel.
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           status,
    output logic [plfr_pkg::FRAME_W-1:0]   frame,
    output logic                           writeback_needed,
    output logic [plfr_pkg::FILE_W-1:0]    writeback_file,
    output logic [plfr_pkg::BLOCK_W-1:0]   writeback_block
);

    localparam int IDX_W = $clog2(FRAMES);
    localparam int CNT_W = $clog2(FRAMES + 1);

    // Frame record layout in the memory.
    localparam int OFF_STAMP = 0;
    localparam int OFF_PIN   = OFF_STAMP + plfr_pkg::STAMP_W;
    localparam int OFF_DIRTY = OFF_PIN + plfr_pkg::PIN_W;
    localparam int OFF_OCC   = OFF_DIRTY + 1;
    localparam int OFF_BLOCK = OFF_OCC + 1;
    localparam int OFF_FILE  = OFF_BLOCK + plfr_pkg::BLOCK_W;
    localparam int OFF_SEEN  = OFF_FILE + plfr_pkg::FILE_W;
    localparam int REC_W     = OFF_SEEN + FILES;

    plfr_pkg::plfr_state_t        state_reg;
    plfr_pkg::plfr_state_t        state_next;

    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    logic [CNT_W-1:0]             cnt_dec;
    logic [IDX_W-1:0]             sel_reg;
    logic [IDX_W-1:0]             sel_next;
    logic [plfr_pkg::STAMP_W-1:0] stamp_reg;
    logic [plfr_pkg::STAMP_W-1:0] stamp_next;
    logic [FRAMES-1:0]            valid_reg;
    logic [FRAMES-1:0]            valid_next;
    logic [IDX_W-1:0]             rd_addr_reg;

    // Latched request payload.
    logic [plfr_pkg::BLOCK_W-1:0] blk_reg;
    logic [plfr_pkg::BLOCK_W-1:0] blk_next;
    logic [plfr_pkg::FILE_W-1:0]  file_reg;
    logic [plfr_pkg::FILE_W-1:0]  file_next;
    logic                         dirty_reg;
    logic                         dirty_next;

    // Result registers.
    logic                         res_status_reg;
    logic                         res_status_next;
    logic [plfr_pkg::FRAME_W-1:0] res_frame_reg;
    logic [plfr_pkg::FRAME_W-1:0] res_frame_next;
    logic                         res_wb_reg;
    logic                         res_wb_next;
    logic [plfr_pkg::FILE_W-1:0]  res_wbf_reg;
    logic [plfr_pkg::FILE_W-1:0]  res_wbf_next;
    logic [plfr_pkg::BLOCK_W-1:0] res_wbb_reg;
    logic [plfr_pkg::BLOCK_W-1:0] res_wbb_next;

    // Datapath wires.
    logic                         accept;
    logic                         forced_in_range;
    logic [31:0]                  forced_ext;
    logic [31:0]                  sel_ext;
    logic                         file_in_range;
    logic [FILES-1:0]             seen_bit;
    logic [REC_W-1:0]             ram_q;
    logic [REC_W-1:0]             rec;
    logic [REC_W-1:0]             new_rec;
    logic [plfr_pkg::PIN_W-1:0]   old_pin;
    logic [plfr_pkg::PIN_W-1:0]   new_pin;
    logic [plfr_pkg::STAMP_W-1:0] stamp_inc;
    logic                         ram_wr_en;
    logic [IDX_W-1:0]             ram_rd_addr;
    plfr_pkg::scan_ctrl_t         scan_ctrl;
    logic [IDX_W-1:0]             scan_idx;
    logic                         vic_found;
    logic [IDX_W-1:0]             vic_idx;

    assign accept          = in_valid && !in_stall;
    assign forced_ext      = 32'(forced_frame);
    assign forced_in_range = forced_ext < 32'(FRAMES);
    assign sel_ext         = 32'(sel_reg);
    assign file_in_range   = 32'(file_reg) < 32'(FILES);
    assign seen_bit        = FILES'(1) << file_reg;
    assign cnt_dec         = cnt_reg - CNT_W'(1);
    assign scan_idx        = cnt_dec[IDX_W-1:0];

    // Frames never written read as the all-zero reset record.
    assign rec = valid_reg[rd_addr_reg] ? ram_q : '0;

    // Updated record of the chosen frame.
    assign old_pin   = rec[OFF_PIN +: plfr_pkg::PIN_W];
    assign new_pin   = (old_pin == plfr_pkg::PIN_MAX) ? old_pin
                                                      : old_pin + plfr_pkg::PIN_W'(1);
    assign stamp_inc = stamp_reg + plfr_pkg::STAMP_W'(1);

    always_comb
    begin
        new_rec                                 = rec;
        new_rec[OFF_STAMP +: plfr_pkg::STAMP_W] = stamp_inc;
        new_rec[OFF_PIN +: plfr_pkg::PIN_W]     = new_pin;
        new_rec[OFF_DIRTY]                      = dirty_reg;
        new_rec[OFF_OCC]                        = 1'b1;
        new_rec[OFF_BLOCK +: plfr_pkg::BLOCK_W] = blk_reg;
        new_rec[OFF_FILE +: plfr_pkg::FILE_W]   = file_reg;
        if (file_in_range)
        begin
            new_rec[OFF_SEEN +: FILES] = rec[OFF_SEEN +: FILES] | seen_bit;
        end
    end

    // Frame record memory.
    plfr_ram #(
        .WIDTH (REC_W),
        .DEPTH (FRAMES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (sel_reg),
        .wr_data (new_rec),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_q)
    );

    // Victim search unit.
    plfr_victim #(
        .FRAMES (FRAMES)
    ) u_victim (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .idx      (scan_idx),
        .stamp    (rec[OFF_STAMP +: plfr_pkg::STAMP_W]),
        .pin      (old_pin),
        .found    (vic_found),
        .best_idx (vic_idx)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plfr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!forced_valid)
                    begin
                        state_next = plfr_pkg::ST_SCAN;
                    end
                    else if (forced_in_range)
                    begin
                        state_next = plfr_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = plfr_pkg::ST_OUT;
                    end
                end
            end
            plfr_pkg::ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(FRAMES))
                begin
                    state_next = plfr_pkg::ST_DECIDE;
                end
            end
            plfr_pkg::ST_DECIDE:
            begin
                state_next = vic_found ? plfr_pkg::ST_LOAD : plfr_pkg::ST_OUT;
            end
            plfr_pkg::ST_LOAD:
            begin
                state_next = plfr_pkg::ST_UPDATE;
            end
            plfr_pkg::ST_UPDATE:
            begin
                state_next = plfr_pkg::ST_OUT;
            end
            plfr_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = plfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plfr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_stall         = 1'b1;
        out_valid        = 1'b0;
        ram_wr_en        = 1'b0;
        ram_rd_addr      = sel_reg;
        scan_ctrl.clear  = 1'b0;
        scan_ctrl.sample = 1'b0;
        case (state_reg)
            plfr_pkg::ST_IDLE:
            begin
                in_stall        = 1'b0;
                scan_ctrl.clear = 1'b1;
            end
            plfr_pkg::ST_SCAN:
            begin
                ram_rd_addr      = cnt_reg[IDX_W-1:0];
                scan_ctrl.sample = (cnt_reg != '0);
            end
            plfr_pkg::ST_UPDATE:
            begin
                ram_wr_en = 1'b1;
            end
            plfr_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        cnt_next        = cnt_reg;
        sel_next        = sel_reg;
        stamp_next      = stamp_reg;
        valid_next      = valid_reg;
        blk_next        = blk_reg;
        file_next       = file_reg;
        dirty_next      = dirty_reg;
        res_status_next = res_status_reg;
        res_frame_next  = res_frame_reg;
        res_wb_next     = res_wb_reg;
        res_wbf_next    = res_wbf_reg;
        res_wbb_next    = res_wbb_reg;
        case (state_reg)
            plfr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next        = '0;
                    sel_next        = forced_ext[IDX_W-1:0];
                    blk_next        = block_number;
                    file_next       = file_id;
                    dirty_next      = dirty_on_load;
                    res_status_next = plfr_pkg::STATUS_NO_FRAME;
                    res_frame_next  = '0;
                    res_wb_next     = 1'b0;
                    res_wbf_next    = '0;
                    res_wbb_next    = '0;
                end
            end
            plfr_pkg::ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            plfr_pkg::ST_DECIDE:
            begin
                sel_next = vic_idx;
            end
            plfr_pkg::ST_UPDATE:
            begin
                stamp_next           = stamp_inc;
                valid_next[sel_reg]  = 1'b1;
                res_status_next      = plfr_pkg::STATUS_OK;
                res_frame_next       = sel_ext[plfr_pkg::FRAME_W-1:0];
                if (rec[OFF_DIRTY])
                begin
                    res_wb_next  = 1'b1;
                    res_wbf_next = rec[OFF_FILE +: plfr_pkg::FILE_W];
                    res_wbb_next = rec[OFF_BLOCK +: plfr_pkg::BLOCK_W];
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plfr_pkg::ST_IDLE;
            cnt_reg   <= '0;
            stamp_reg <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stamp_reg <= stamp_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sel_reg        <= sel_next;
        rd_addr_reg    <= ram_rd_addr;
        blk_reg        <= blk_next;
        file_reg       <= file_next;
        dirty_reg      <= dirty_next;
        res_status_reg <= res_status_next;
        res_frame_reg  <= res_frame_next;
        res_wb_reg     <= res_wb_next;
        res_wbf_reg    <= res_wbf_next;
        res_wbb_reg    <= res_wbb_next;
    end

    assign status           = res_status_reg;
    assign frame            = res_frame_reg;
    assign writeback_needed = res_wb_reg;
    assign writeback_file   = res_wbf_reg;
    assign writeback_block  = res_wbb_reg;

    // A no-frame result carries no frame and no write-back.
    a_no_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == plfr_pkg::STATUS_NO_FRAME))
            |-> ((frame == '0) && !writeback_needed))
        else $error("no-frame result carries a frame or a write-back");

    // The global stamp moves only when a frame is installed.
    a_stamp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != plfr_pkg::ST_UPDATE) |=> $stable(stamp_reg))
        else $error("global stamp changed outside an install");

    // Frame valid bits are never cleared once set.
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("frame valid bit cleared");

    // Memory writes happen only while no item is being taken or offered.
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (in_stall && !out_valid))
        else $error("frame record written while a channel is active");

endmodule

>>> hdl/plfr_ram.sv
// ----------------------------------------------------------------------------
// plfr_ram: generic single-write, single-read memory.
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module plfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/plfr_victim.sv
// ----------------------------------------------------------------------------
// plfr_victim: victim search unit.
// Takes one frame record per sample and keeps the lowest-indexed unpinned
// frame with the smallest use stamp, through one shared 32-bit comparator.
// ----------------------------------------------------------------------------
module plfr_victim #(
    parameter int FRAMES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  plfr_pkg::scan_ctrl_t              ctrl,
    input  logic [$clog2(FRAMES)-1:0]         idx,
    input  logic [plfr_pkg::STAMP_W-1:0]      stamp,
    input  logic [plfr_pkg::PIN_W-1:0]        pin,
    output logic                              found,
    output logic [$clog2(FRAMES)-1:0]         best_idx
);

    localparam int IDX_W = $clog2(FRAMES);

    logic                         found_reg;
    logic                         found_next;
    logic [IDX_W-1:0]             best_idx_reg;
    logic [IDX_W-1:0]             best_idx_next;
    logic [plfr_pkg::STAMP_W-1:0] best_stamp_reg;
    logic [plfr_pkg::STAMP_W-1:0] best_stamp_next;
    logic                         take;

    // Shared comparator: a strictly smaller stamp keeps the earlier frame on ties.
    assign take = (pin == '0) && (!found_reg || (stamp < best_stamp_reg));

    always_comb
    begin
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctrl.sample && take)
        begin
            found_next      = 1'b1;
            best_idx_next   = idx;
            best_stamp_next = stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    // Best candidate payload.
    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;

endmodule

>>> tb/plfr_replacement_checker.sv
// ----------------------------------------------------------------------------
// plfr_replacement_checker: result checker for the pinned LRU frame replacer.
// Watches the request and result channels, keeps its own copy of the frame
// table, predicts the frame choice and write-back for every accepted request
// and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module plfr_replacement_checker #(
    parameter int FRAMES = 16,
    parameter int FILES  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           forced_valid,
    input  logic [plfr_pkg::FRAME_W-1:0]   forced_frame,
    input  logic [plfr_pkg::BLOCK_W-1:0]   block_number,
    input  logic [plfr_pkg::FILE_W-1:0]    file_id,
    input  logic                           dirty_on_load,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           status,
    input  logic [plfr_pkg::FRAME_W-1:0]   frame,
    input  logic                           writeback_needed,
    input  logic [plfr_pkg::FILE_W-1:0]    writeback_file,
    input  logic [plfr_pkg::BLOCK_W-1:0]   writeback_block,
    output int                             mismatches,
    output int                             outstanding
);

    // One predicted result item.
    typedef struct packed {
        logic                         status;
        logic [plfr_pkg::FRAME_W-1:0] frame;
        logic                         wb_needed;
        logic [plfr_pkg::FILE_W-1:0]  wb_file;
        logic [plfr_pkg::BLOCK_W-1:0] wb_block;
    } frame_choice_t;

    // Shadow copy of the frame table.
    logic [plfr_pkg::STAMP_W-1:0] use_stamp_q [FRAMES];
    logic [plfr_pkg::PIN_W-1:0]   pin_q       [FRAMES];
    logic                         dirty_q     [FRAMES];
    logic                         occupied_q  [FRAMES];
    logic [plfr_pkg::BLOCK_W-1:0] block_q     [FRAMES];
    logic [plfr_pkg::FILE_W-1:0]  owner_q     [FRAMES];
    logic [FILES-1:0]             file_seen_q [FRAMES];
    logic [plfr_pkg::STAMP_W-1:0] use_clock_q;

    // Predicted results not yet seen on the result channel.
    frame_choice_t frame_choices_q [$];

    // Picks the frame for one request, updates the shadow table and returns
    // the result the block should give.
    function automatic frame_choice_t choose_frame(
        input logic                         use_forced,
        input logic [plfr_pkg::FRAME_W-1:0] forced_idx,
        input logic [plfr_pkg::BLOCK_W-1:0] blk,
        input logic [plfr_pkg::FILE_W-1:0]  fid,
        input logic                         dirty_in
    );
        int                           victim;
        logic [plfr_pkg::STAMP_W-1:0] oldest;
        frame_choice_t                r;
        r      = '0;
        victim = -1;
        oldest = '0;
        if (use_forced)
        begin
            victim = (int'(forced_idx) < FRAMES) ? int'(forced_idx) : -1;
        end
        else
        begin
            // Lowest-indexed unpinned frame with the smallest stamp wins.
            for (int k = 0; k < FRAMES; k++)
            begin
                if (pin_q[k] == '0 && (victim < 0 || use_stamp_q[k] < oldest))
                begin
                    victim = k;
                    oldest = use_stamp_q[k];
                end
            end
        end
        if (victim < 0)
        begin
            r.status = plfr_pkg::STATUS_NO_FRAME;
            return r;
        end
        r.status = plfr_pkg::STATUS_OK;
        r.frame  = victim[plfr_pkg::FRAME_W-1:0];
        if (dirty_q[victim])
        begin
            r.wb_needed = 1'b1;
            r.wb_file   = owner_q[victim];
            r.wb_block  = block_q[victim];
        end
        // Install the new block and pin it once more.
        use_clock_q         = use_clock_q + 1'b1;
        use_stamp_q[victim] = use_clock_q;
        block_q[victim]     = blk;
        owner_q[victim]     = fid;
        if (pin_q[victim] != plfr_pkg::PIN_MAX)
            pin_q[victim] = pin_q[victim] + 1'b1;
        dirty_q[victim]    = dirty_in;
        occupied_q[victim] = 1'b1;
        if (int'(fid) < FILES)
            file_seen_q[victim][fid] = 1'b1;
        return r;
    endfunction

    // Track both channels; results are checked before new requests are
    // predicted so that a same-edge pair is handled in order.
    always @(posedge clk or negedge rst_n)
    begin
        frame_choice_t got;
        frame_choice_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < FRAMES; k++)
            begin
                use_stamp_q[k] = '0;
                pin_q[k]       = '0;
                dirty_q[k]     = 1'b0;
                occupied_q[k]  = 1'b0;
                block_q[k]     = '0;
                owner_q[k]     = '0;
                file_seen_q[k] = '0;
            end
            use_clock_q = '0;
            frame_choices_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got = {status, frame, writeback_needed, writeback_file, writeback_block};
                if (frame_choices_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result item: status %0d frame %0d",
                                 $realtime, got.status, got.frame);
                end
                else
                begin
                    want = frame_choices_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch: expected status %0d frame %0d",
                                     $realtime, want.status, want.frame,
                                     " wb %0d file %0d block %h,",
                                     want.wb_needed, want.wb_file, want.wb_block,
                                     " got status %0d frame %0d", got.status, got.frame,
                                     " wb %0d file %0d block %h",
                                     got.wb_needed, got.wb_file, got.wb_block);
                    end
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                frame_choices_q.push_back(choose_frame(forced_valid, forced_frame,
                                                       block_number, file_id,
                                                       dirty_on_load));
            outstanding = frame_choices_q.size();
        end
    end

endmodule

>>> tb/tb_pinned_lru_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// tb_pinned_lru_frame_replacer_core: testbench of the frame replacer core.
// Drives a directed set of requests (victim searches, forced frames, dirty
// write-backs, a fully pinned pool) and then random requests weighted so one
// frame reaches pin saturation, with random gaps and result stalls. A
// separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pinned_lru_frame_replacer_core;

    localparam int N_FRAMES        = 16;
    localparam int N_FILES         = 16;
    localparam int RANDOM_REQUESTS = 1350;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOT_FRAME       = 3;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         forced_valid;
    logic [plfr_pkg::FRAME_W-1:0] forced_frame;
    logic [plfr_pkg::BLOCK_W-1:0] block_number;
    logic [plfr_pkg::FILE_W-1:0]  file_id;
    logic                         dirty_on_load;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         status;
    logic [plfr_pkg::FRAME_W-1:0] frame;
    logic                         writeback_needed;
    logic [plfr_pkg::FILE_W-1:0]  writeback_file;
    logic [plfr_pkg::BLOCK_W-1:0] writeback_block;

    int mismatches;
    int outstanding;
    int cycle_count  = 0;
    int stall_left   = 0;
    bit steady       = 1'b0;
    bit result_taken = 1'b0;

    pinned_lru_frame_replacer_core #(
        .FRAMES (N_FRAMES),
        .FILES  (N_FILES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .forced_valid     (forced_valid),
        .forced_frame     (forced_frame),
        .block_number     (block_number),
        .file_id          (file_id),
        .dirty_on_load    (dirty_on_load),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .frame            (frame),
        .writeback_needed (writeback_needed),
        .writeback_file   (writeback_file),
        .writeback_block  (writeback_block)
    );

    plfr_replacement_checker #(
        .FRAMES (N_FRAMES),
        .FILES  (N_FILES)
    ) replace_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .forced_valid     (forced_valid),
        .forced_frame     (forced_frame),
        .block_number     (block_number),
        .file_id          (file_id),
        .dirty_on_load    (dirty_on_load),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .frame            (frame),
        .writeback_needed (writeback_needed),
        .writeback_file   (writeback_file),
        .writeback_block  (writeback_block),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_pinned_lru_frame_replacer_core: done, errors");
            $finish;
        end
    end

    // Result side: after each taken item, hold off the next one for a drawn
    // number of cycles in which a result is on offer.
    always @(posedge clk)
    begin
        result_taken <= (rst_n === 1'b1) && (out_valid === 1'b1) && (out_stall === 1'b0);
    end

    always @(negedge clk)
    begin
        if (result_taken)
            stall_left = steady ? 0 : $urandom_range(0, 19);
        out_stall <= (stall_left != 0);
        if (out_valid === 1'b1 && stall_left != 0)
            stall_left--;
    end

    // Offer one request item after a drawn gap and wait until it is taken.
    task automatic send_request(
        input logic                         use_forced,
        input logic [plfr_pkg::FRAME_W-1:0] forced_idx,
        input logic [plfr_pkg::BLOCK_W-1:0] blk,
        input logic [plfr_pkg::FILE_W-1:0]  fid,
        input logic                         dirty_in
    );
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        forced_valid  <= use_forced;
        forced_frame  <= forced_idx;
        block_number  <= blk;
        file_id       <= fid;
        dirty_on_load <= dirty_in;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic                         use_forced;
        logic [plfr_pkg::FRAME_W-1:0] idx;
        logic [plfr_pkg::BLOCK_W-1:0] blk;
        logic [plfr_pkg::FILE_W-1:0]  fid;
        logic                         dirty_in;
        in_valid      = 1'b0;
        forced_valid  = 1'b0;
        forced_frame  = '0;
        block_number  = '0;
        file_id       = '0;
        dirty_on_load = 1'b0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Searches into an empty pool, then write-backs of dirty frames with
        // extreme block and file values.
        send_request(1'b0, 4'd9, 16'h0000, 4'd0, 1'b1);
        send_request(1'b0, 4'd0, 16'hFFFF, 4'hF, 1'b1);
        send_request(1'b1, 4'd0, 16'h1234, 4'd5, 1'b0);
        send_request(1'b1, 4'd1, 16'h0000, 4'd0, 1'b1);
        send_request(1'b1, 4'hF, 16'hAAAA, 4'hA, 1'b1);
        send_request(1'b0, 4'hF, 16'h5555, 4'd3, 1'b0);
        // A forced frame that is already pinned is still used.
        send_request(1'b1, 4'd0, 16'h8001, 4'd7, 1'b0);
        // Pin every remaining frame, then search a fully pinned pool.
        for (int f = 3; f < N_FRAMES - 1; f++)
            send_request(1'b1, plfr_pkg::FRAME_W'(f),
                         plfr_pkg::BLOCK_W'($urandom_range(0, 65535)),
                         plfr_pkg::FILE_W'($urandom_range(0, 15)), 1'b1);
        send_request(1'b0, 4'd0, 16'hFFFF, 4'hF, 1'b1);
        send_request(1'b1, 4'hF, 16'h0F0F, 4'd1, 1'b0);

        // Random requests: mostly forced, with one frame hit often enough to
        // saturate its pin count.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            use_forced = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) < 7)
                idx = plfr_pkg::FRAME_W'(HOT_FRAME);
            else
                idx = plfr_pkg::FRAME_W'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
                0:       blk = '0;
                1:       blk = '1;
                default: blk = plfr_pkg::BLOCK_W'($urandom_range(0, 65535));
            endcase
            fid      = plfr_pkg::FILE_W'($urandom_range(0, 15));
            dirty_in = 1'($urandom_range(0, 1));
            send_request(use_forced, idx, blk, fid, dirty_in);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain outstanding results, then allow for any stray output.
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_pinned_lru_frame_replacer_core: done, clean");
        else
            $display("tb_pinned_lru_frame_replacer_core: done, errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/plfr_pkg.sv
hdl/plfr_ram.sv
hdl/plfr_victim.sv
hdl/pinned_lru_frame_replacer_core.sv
tb/plfr_replacement_checker.sv
tb/tb_pinned_lru_frame_replacer_core.sv
